@@ rtl/bmhpq_pkg.sv @@
// Package for the min-heap priority queue: widths, codes and the command
// struct that the top level sends down the cell row. No dependencies.
`timescale 1ns / 1ps

package bmhpq_pkg;

   localparam int KEY_W            = 32;
   localparam int COUNT_OUT_W      = 11;
   localparam int STATUS_W         = 2;
   localparam int DEFAULT_CAPACITY = 1024;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // one row update: at most one of push and pop is set
   typedef struct packed {
      logic                    push;
      logic                    pop;
      logic signed [KEY_W-1:0] key;
   } cmd_type;

endpackage

@@ rtl/bmhpq_cell.sv @@
// One cell of the sorted key row: holds one key, inserts or shifts.
// Depends on bmhpq_pkg.
`timescale 1ns / 1ps

module bmhpq_cell #(
   parameter int CNT_W = 11,
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  bmhpq_pkg::cmd_type                cmd,
   input  logic [CNT_W-1:0]                  count,
   input  logic signed [bmhpq_pkg::KEY_W-1:0] left_value,
   input  logic                              left_take,
   input  logic signed [bmhpq_pkg::KEY_W-1:0] right_value,
   output logic signed [bmhpq_pkg::KEY_W-1:0] value,
   output logic                              take
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic signed [bmhpq_pkg::KEY_W-1:0] value_ff;
   logic signed [bmhpq_pkg::KEY_W-1:0] value_in;
   logic                               occupied;

   assign occupied = IDX < count;
   // new key goes at or before this cell (empty cells count as +inf)
   assign take     = !occupied || (cmd.key < value_ff);
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (cmd.push && take) begin
         // left neighbor displaced too: take its key, else the new one
         value_in = left_take ? left_value : cmd.key;
      end else if (cmd.pop) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ rtl/bmhpq_chain.sv @@
// Row of bmhpq_cell instances kept in ascending order, head at cell 0.
// Depends on bmhpq_pkg and bmhpq_cell.
`timescale 1ns / 1ps

module bmhpq_chain #(
   parameter int CAPACITY = bmhpq_pkg::DEFAULT_CAPACITY,
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                               clock,
   input  bmhpq_pkg::cmd_type                 cmd,
   input  logic [CNT_W-1:0]                   count,
   output logic signed [bmhpq_pkg::KEY_W-1:0] head_key
);

   logic signed [bmhpq_pkg::KEY_W-1:0] value [CAPACITY];
   logic                               take  [CAPACITY];

   assign head_key = value[0];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [bmhpq_pkg::KEY_W-1:0] lv;
      logic                               lt;
      logic signed [bmhpq_pkg::KEY_W-1:0] rv;

      if (i == 0) begin : g_first
         assign lv = '0;
         assign lt = 1'b0;
      end else begin : g_mid
         assign lv = value[i-1];
         assign lt = take[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rv = '0;
      end else begin : g_next
         assign rv = value[i+1];
      end

      bmhpq_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count),
         .left_value  (lv),
         .left_take   (lt),
         .right_value (rv),
         .value       (value[i]),
         .take        (take[i])
      );
   end

endmodule

@@ rtl/binary_min_heap_priority_queue_top.sv @@
// Top level of the min-priority queue of signed keys: command port,
// count and status logic, and the sorted cell row. Depends on bmhpq_pkg,
// bmhpq_chain and bmhpq_cell.
`timescale 1ns / 1ps

//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------
//  request  | req_action, req_key_in                 | start high, busy low
//  response | rsp_key_out, rsp_status, rsp_count_after| rsp_strobe, one cycle
//
// For each item the command is registered first; then every cell of the
// row updates at once (insert with shift right, or shift left on pop).
// busy is high for the cycle after an accept; the result strobes in the
// cycle after that, while the next item may already be taken.
// Synchronous active-high reset empties the queue; cell contents need none.
// The receiver cannot stall, so results are never held.
//
// Keys sit in ascending order, so a pop hands out cell 0. Equal keys keep
// arrival order, which does not change any value that is returned.

module binary_min_heap_priority_queue_top #(
   parameter int CAPACITY = bmhpq_pkg::DEFAULT_CAPACITY
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic                                     req_action,
   input  logic signed [bmhpq_pkg::KEY_W-1:0]       req_key_in,
   output logic                                     rsp_strobe,
   output logic signed [bmhpq_pkg::KEY_W-1:0]       rsp_key_out,
   output logic [bmhpq_pkg::STATUS_W-1:0]           rsp_status,
   output logic [bmhpq_pkg::COUNT_OUT_W-1:0]        rsp_count_after
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   // command stage
   logic                               busy_ff;
   logic                               busy_in;
   logic                               action_ff;
   logic signed [bmhpq_pkg::KEY_W-1:0] key_ff;

   // queue state
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;

   // response registers
   logic                                  rsp_valid_ff;
   logic signed [bmhpq_pkg::KEY_W-1:0]    rsp_key_ff;
   logic signed [bmhpq_pkg::KEY_W-1:0]    rsp_key_in;
   bmhpq_pkg::status_type                 rsp_status_ff;
   bmhpq_pkg::status_type                 rsp_status_in;
   logic [bmhpq_pkg::COUNT_OUT_W-1:0]     rsp_count_ff;

   logic                               accept;
   logic                               full;
   logic                               empty;
   bmhpq_pkg::cmd_type                 cmd;
   logic signed [bmhpq_pkg::KEY_W-1:0] head_key;

   assign accept = start && !busy_ff;
   assign busy_in = accept;
   assign full   = count_ff == FULL_COUNT;
   assign empty  = count_ff == '0;

   always_comb begin
      cmd.key       = key_ff;
      cmd.push      = 1'b0;
      cmd.pop       = 1'b0;
      count_in      = count_ff;
      rsp_key_in    = '0;
      rsp_status_in = bmhpq_pkg::STATUS_OK;
      if (busy_ff) begin
         if (action_ff == bmhpq_pkg::ACTION_PUSH) begin
            if (full) begin
               rsp_status_in = bmhpq_pkg::STATUS_FULL;
            end else begin
               cmd.push = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (empty) begin
               rsp_status_in = bmhpq_pkg::STATUS_EMPTY;
            end else begin
               cmd.pop    = 1'b1;
               rsp_key_in = head_key;
               count_in   = count_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         key_ff    <= req_key_in;
      end
      if (busy_ff) begin
         rsp_key_ff    <= rsp_key_in;
         rsp_status_ff <= rsp_status_in;
         // count field is the low bits of the updated count
         rsp_count_ff  <= bmhpq_pkg::COUNT_OUT_W'(count_in);
      end
   end

   bmhpq_chain #(
      .CAPACITY (CAPACITY),
      .CNT_W    (CNT_W)
   ) u_chain (
      .clock    (clock),
      .cmd      (cmd),
      .count    (count_ff),
      .head_key (head_key)
   );

   assign busy            = busy_ff;
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count_after = rsp_count_ff;

endmodule

@@ sim/binary_min_heap_priority_queue_top_tb.sv @@
// Self-checking bench for the min-priority queue top: directed and random
// push/pop items checked against a heap predictor kept in a small scoreboard class.
// Depends on bmhpq_pkg and binary_min_heap_priority_queue_top.
`timescale 1ns / 1ps

module binary_min_heap_priority_queue_top_tb;

   localparam int CAP        = bmhpq_pkg::DEFAULT_CAPACITY;
   localparam int CYCLE_MAX  = 100000;
   localparam int DRAIN_WAIT = 10;       // result trails its accept through the busy and response-valid registers

   // expected outcome of one item
   typedef struct {
      logic signed [bmhpq_pkg::KEY_W-1:0]  key;
      bmhpq_pkg::status_type               status;
      logic [bmhpq_pkg::COUNT_OUT_W-1:0]   count;
   } heap_result_type;

   // Keeps its own array heap and the queue of results still owed by the DUT.
   class pq_scoreboard_type;
      logic signed [bmhpq_pkg::KEY_W-1:0] slots [CAP];
      int unsigned                        held;
      heap_result_type                    pending_results [$];
      int                                 fail_count;

      function new();
         held       = 0;
         fail_count = 0;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic signed [bmhpq_pkg::KEY_W-1:0] t;
         t        = slots[a];
         slots[a] = slots[b];
         slots[b] = t;
      endfunction

      // accepted item: update the heap and queue the result it must give
      function void note_item(logic act, logic signed [bmhpq_pkg::KEY_W-1:0] key);
         heap_result_type r;
         int unsigned     pos, parent, lchild, rchild, pick;
         r.key    = '0;
         r.status = bmhpq_pkg::STATUS_OK;
         if (act == bmhpq_pkg::ACTION_PUSH) begin
            if (held >= CAP) begin
               r.status = bmhpq_pkg::STATUS_FULL;
            end else begin
               slots[held] = key;
               pos = held;
               while (pos > 0) begin
                  parent = (pos - 1) / 2;
                  if (!(slots[pos] < slots[parent])) break;
                  swap_slots(pos, parent);
                  pos = parent;
               end
               held++;
            end
         end else begin
            if (held == 0) begin
               r.status = bmhpq_pkg::STATUS_EMPTY;
            end else begin
               r.key = slots[0];
               held--;
               if (held > 0) begin
                  slots[0] = slots[held];
                  pos = 0;
                  forever begin
                     lchild = 2 * pos + 1;
                     rchild = lchild + 1;
                     if (lchild >= held) break;
                     pick = lchild;   // left wins ties
                     if (rchild < held && slots[rchild] < slots[lchild]) pick = rchild;
                     if (!(slots[pick] < slots[pos])) break;
                     swap_slots(pick, pos);
                     pos = pick;
                  end
               end
            end
         end
         r.count = bmhpq_pkg::COUNT_OUT_W'(held);
         pending_results.push_back(r);
      endfunction

      function void check_result(logic signed [bmhpq_pkg::KEY_W-1:0] key,
                                 logic [bmhpq_pkg::STATUS_W-1:0] status,
                                 logic [bmhpq_pkg::COUNT_OUT_W-1:0] count);
         heap_result_type e;
         if (pending_results.size() == 0) begin
            $error("result with none expected: key_out %0d status %0d count_after %0d",
                   key, status, count);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (key !== e.key) begin
               $error("key_out mismatch: expected %0d, got %0d", e.key, key);
               fail_count++;
            end
            if (status !== e.status) begin
               $error("status mismatch: expected %0d, got %0d", e.status, status);
               fail_count++;
            end
            if (count !== e.count) begin
               $error("count_after mismatch: expected %0d, got %0d", e.count, count);
               fail_count++;
            end
         end
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_action;
   logic signed [bmhpq_pkg::KEY_W-1:0]  req_key_in;
   logic                                rsp_strobe;
   logic signed [bmhpq_pkg::KEY_W-1:0]  rsp_key_out;
   logic [bmhpq_pkg::STATUS_W-1:0]      rsp_status;
   logic [bmhpq_pkg::COUNT_OUT_W-1:0]   rsp_count_after;

   pq_scoreboard_type sb;
   int                cycle_count;
   int                items_sent;    // drives the idle schedule
   int unsigned       queued_keys;   // stimulus-side occupancy, steers the mix

   binary_min_heap_priority_queue_top #(.CAPACITY(CAP)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key_in      (req_key_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_key_out     (rsp_key_out),
      .rsp_status      (rsp_status),
      .rsp_count_after (rsp_count_after)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watch both channels at each edge. Everything here reads pre-edge values:
   // the bench drives with NBAs and the DUT outputs are registered.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_item(req_action, req_key_in);
         if (rsp_strobe) sb.check_result(rsp_key_out, rsp_status, rsp_count_after);
      end
   end

   // hard stop in case the DUT hangs or drops results
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Idle schedule: each idle-gap draw succeeds with a 7 percent chance first, then
   // 80 percent, then back to back for the tail of the run.
   function automatic int idle_pct(int n);
      if (n < 470) return 7;
      if (n < 940) return 80;
      return 0;
   endfunction

   // Key mix: extremes, a narrow band around zero for duplicates, and
   // full-range values so every bit toggles.
   function automatic logic signed [bmhpq_pkg::KEY_W-1:0] rand_key();
      case ($urandom_range(9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3:    return bmhpq_pkg::KEY_W'(int'($urandom_range(8)) - 4);
         default: return $urandom;
      endcase
   endfunction

   // Present one item and hold it until accepted. start only drops during an
   // idle gap, so it never sees two NBAs in the same step.
   task automatic send_item(logic act, logic signed [bmhpq_pkg::KEY_W-1:0] key,
                            int gap_pct);
      while (int'($urandom_range(99)) < gap_pct) begin
         start      <= 1'b0;
         req_action <= 1'($urandom_range(1));   // noise while idle
         req_key_in <= $urandom;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= act;
      req_key_in <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (act == bmhpq_pkg::ACTION_PUSH) begin
         if (queued_keys < CAP) queued_keys++;
      end else if (queued_keys > 0) begin
         queued_keys--;
      end
   endtask

   task automatic send_mix(int push_pct);
      send_item((int'($urandom_range(99)) < push_pct) ? bmhpq_pkg::ACTION_PUSH
                                                       : bmhpq_pkg::ACTION_POP,
                rand_key(), idle_pct(items_sent));
   endtask

   initial begin
      sb          = new();
      cycle_count = 0;
      items_sent  = 0;
      queued_keys = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_action  = bmhpq_pkg::ACTION_PUSH;
      req_key_in  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: pop on empty, key extremes, alternating bit patterns,
      // equal keys, then drain past the last key into empty again
      send_item(bmhpq_pkg::ACTION_POP,  $urandom,          0);
      send_item(bmhpq_pkg::ACTION_PUSH, 32'sh7FFF_FFFF,    0);
      send_item(bmhpq_pkg::ACTION_PUSH, 32'sh8000_0000,    0);
      send_item(bmhpq_pkg::ACTION_PUSH, 32'sh0000_0000,    0);
      send_item(bmhpq_pkg::ACTION_PUSH, -32'sd1,           0);
      send_item(bmhpq_pkg::ACTION_PUSH, 32'sh5555_5555,    0);
      send_item(bmhpq_pkg::ACTION_PUSH, 32'shAAAA_AAAA,    0);
      send_item(bmhpq_pkg::ACTION_PUSH, 32'sd5,            0);
      send_item(bmhpq_pkg::ACTION_PUSH, 32'sd5,            0);
      send_item(bmhpq_pkg::ACTION_PUSH, 32'sd5,            0);
      send_item(bmhpq_pkg::ACTION_POP,  32'sh7FFF_FFFF,    0);
      send_item(bmhpq_pkg::ACTION_POP,  $urandom,          0);
      send_item(bmhpq_pkg::ACTION_PUSH, -32'sd1,           0);
      repeat (9) send_item(bmhpq_pkg::ACTION_POP, $urandom, 0);   // last one hits empty
      send_item(bmhpq_pkg::ACTION_PUSH, 32'sd7,            0);
      send_item(bmhpq_pkg::ACTION_POP,  32'sd0,            0);    // pop of the only key
      send_item(bmhpq_pkg::ACTION_POP,  -32'sd1,           0);

      // random: churn near empty, fill to capacity, hover at full so
      // pushes get refused, then pop-heavy drain
      repeat (150) send_mix(50);
      while (queued_keys < CAP) send_mix(96);
      repeat (30) send_mix(60);
      repeat (120) send_mix(20);

      start <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
